>>> sv/ddo_pkg.sv
// ----------------------------------------------------------------------------
// ddo_pkg: shared types and constants for differential-drive odometry
// Command/status structures, register indexes, fixed-point constants and
// the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package ddo_pkg;

    // CORDIC iteration count and pose fraction bits
    localparam int CORDIC_STEPS       = 16;
    localparam int POSE_FRACTION_BITS = 32;

    localparam int CORDIC_N   = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
    localparam int CNT_W      = (CORDIC_N > 1) ? $clog2(CORDIC_N) : 1;
    localparam int STEP_SHIFT = 44 - POSE_FRACTION_BITS;
    localparam int POSE_LSB   = POSE_FRACTION_BITS - 16;

    localparam int ACC_W   = 48;
    localparam int CFG_W   = 32;
    localparam int CFG_IDX_W = 8;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TRAVEL_SCALE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_SCALE   = 8'd1;

    localparam logic [31:0] TRAVEL_SCALE_RST = 32'd40779;
    localparam logic [31:0] TURN_SCALE_RST   = 32'd28845;

    localparam logic signed [31:0] CORDIC_GAIN_Q28 = 32'sd163008218;

    // wheel delta wrap limits
    localparam logic signed [17:0] DELTA_LIMIT = 18'sd32766;
    localparam logic signed [17:0] DELTA_WRAP  = 18'sd65533;

    // multiplier operand selection
    typedef enum logic [1:0] {
        MUL_DS = 2'd0,
        MUL_P  = 2'd1,
        MUL_HI = 2'd2,
        MUL_LO = 2'd3
    } mul_op_t;

    // controller to datapath
    typedef struct packed {
        logic    load;
        mul_op_t mul_op;
        logic    axis_y;
        logic    ds_capture;
        logic    mid_init;
        logic    rotate;
        logic    hold_capture;
        logic    acc_x;
        logic    acc_y;
        logic    out_write;
    } ddo_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic primed;
        logic rotate_last;
    } ddo_status_t;

    // arctangent table, binary angle (2^32 per turn)
    function automatic logic [31:0] atan_entry(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'h2000_0000;
            5'd1:    v = 32'h12E4_051E;
            5'd2:    v = 32'h09FB_385B;
            5'd3:    v = 32'h0511_11D4;
            5'd4:    v = 32'h028B_0D43;
            5'd5:    v = 32'h0145_D7E1;
            5'd6:    v = 32'h00A2_F61E;
            5'd7:    v = 32'h0051_7C55;
            5'd8:    v = 32'h0028_BE53;
            5'd9:    v = 32'h0014_5F2F;
            5'd10:   v = 32'h000A_2F98;
            5'd11:   v = 32'h0005_17CC;
            5'd12:   v = 32'h0002_8BE6;
            5'd13:   v = 32'h0001_45F3;
            5'd14:   v = 32'h0000_A2FA;
            5'd15:   v = 32'h0000_517D;
            5'd16:   v = 32'h0000_28BE;
            5'd17:   v = 32'h0000_145F;
            5'd18:   v = 32'h0000_0A30;
            5'd19:   v = 32'h0000_0518;
            5'd20:   v = 32'h0000_028C;
            5'd21:   v = 32'h0000_0146;
            5'd22:   v = 32'h0000_00A3;
            5'd23:   v = 32'h0000_0051;
            5'd24:   v = 32'h0000_0029;
            5'd25:   v = 32'h0000_0014;
            5'd26:   v = 32'h0000_000A;
            5'd27:   v = 32'h0000_0005;
            5'd28:   v = 32'h0000_0003;
            5'd29:   v = 32'h0000_0001;
            5'd30:   v = 32'h0000_0001;
            default: v = 32'h0000_0000;
        endcase
        return v;
    endfunction

endpackage

>>> sv/ddo_datapath.sv
// ----------------------------------------------------------------------------
// ddo_datapath: odometry arithmetic
// Wheel deltas, shared multiplier, heading update, iterative CORDIC,
// pose accumulators, configuration registers and output registers.
// ----------------------------------------------------------------------------
module ddo_datapath
    import ddo_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  ddo_cmd_t              cmd,
    output ddo_status_t           status,
    input  logic [15:0]           left_position,
    input  logic [15:0]           right_position,
    input  logic                  cfg_write_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data,
    output logic signed [31:0]    pose_x,
    output logic signed [31:0]    pose_y,
    output logic [15:0]           heading
);

    // wrapped wheel delta
    function automatic logic signed [16:0] wheel_delta(input logic [15:0] prev,
                                                       input logic [15:0] cur);
        logic signed [17:0] d;
        d = $signed({2'b00, cur}) - $signed({2'b00, prev});
        if (d > DELTA_LIMIT)
            d = d - DELTA_WRAP;
        else if (d < -DELTA_LIMIT)
            d = d + DELTA_WRAP;
        return d[16:0];
    endfunction

    logic [31:0]              travel_scale_reg;
    logic [31:0]              turn_scale_reg;
    logic [15:0]              last_left_reg;
    logic [15:0]              last_right_reg;
    logic                     primed_reg;
    logic signed [17:0]       sum_reg;
    logic signed [17:0]       diff_reg;
    logic signed [63:0]       prod_reg;
    logic signed [63:0]       hold_reg;
    logic signed [49:0]       ds_reg;
    logic [31:0]              heading_acc_reg;
    logic [1:0]               quad_reg;
    logic signed [31:0]       cx_reg;
    logic signed [31:0]       cy_reg;
    logic signed [31:0]       cz_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic [ACC_W-1:0]         acc_x_reg;
    logic [ACC_W-1:0]         acc_y_reg;
    logic signed [31:0]       pose_x_reg;
    logic signed [31:0]       pose_y_reg;
    logic [15:0]              heading_reg;

    logic signed [16:0]       dl;
    logic signed [16:0]       dr_raw;
    logic signed [17:0]       dl_ext;
    logic signed [17:0]       dr_ext;
    logic signed [33:0]       mul_a;
    logic signed [32:0]       mul_b;
    logic signed [66:0]       mul_full;
    logic signed [31:0]       cos_val;
    logic signed [31:0]       sin_val;
    logic signed [31:0]       c_sel;
    logic [31:0]              mid;
    logic [31:0]              mid_bias;
    logic [1:0]               quad;
    logic signed [31:0]       xs;
    logic signed [31:0]       ys;
    logic [31:0]              atan_val;
    logic signed [63:0]       t_sum;
    logic signed [63:0]       step;
    logic signed [63:0]       sext_x;
    logic signed [63:0]       sext_y;

    // wheel deltas, right wheel negated
    always_comb
    begin
        dl     = wheel_delta(last_left_reg, left_position);
        dr_raw = wheel_delta(last_right_reg, right_position);
        dl_ext = {dl[16], dl};
        dr_ext = -{dr_raw[16], dr_raw};
    end

    // quadrant restore of CORDIC result
    always_comb
    begin
        case (quad_reg)
            2'd0:
            begin
                cos_val = cx_reg;
                sin_val = cy_reg;
            end
            2'd1:
            begin
                cos_val = -cy_reg;
                sin_val = cx_reg;
            end
            2'd2:
            begin
                cos_val = -cx_reg;
                sin_val = -cy_reg;
            end
            default:
            begin
                cos_val = cy_reg;
                sin_val = -cx_reg;
            end
        endcase
        c_sel = cmd.axis_y ? sin_val : cos_val;
    end

    // shared multiplier operand select
    always_comb
    begin
        case (cmd.mul_op)
            MUL_DS:
            begin
                mul_a = {{16{sum_reg[17]}}, sum_reg};
                mul_b = {1'b0, travel_scale_reg};
            end
            MUL_P:
            begin
                mul_a = {{16{diff_reg[17]}}, diff_reg};
                mul_b = {1'b0, turn_scale_reg};
            end
            MUL_HI:
            begin
                mul_a = ds_reg[49:16];
                mul_b = {c_sel[31], c_sel};
            end
            default:
            begin
                mul_a = {18'd0, ds_reg[15:0]};
                mul_b = {c_sel[31], c_sel};
            end
        endcase
        mul_full = mul_a * mul_b;
    end

    // midpoint heading and quadrant reduction
    always_comb
    begin
        mid      = heading_acc_reg + prod_reg[32:1];
        mid_bias = mid + 32'h2000_0000;
        quad     = mid_bias[31:30];
    end

    // CORDIC step terms
    always_comb
    begin
        xs       = cx_reg >>> cnt_reg;
        ys       = cy_reg >>> cnt_reg;
        atan_val = atan_entry(5'(cnt_reg));
    end

    // pose step: hi*c + floor(lo*c / 2^16), then scaled to accumulator
    always_comb
    begin
        t_sum  = hold_reg + (prod_reg >>> 16);
        step   = t_sum >>> STEP_SHIFT;
        sext_x = {{(64-ACC_W){acc_x_reg[ACC_W-1]}}, acc_x_reg};
        sext_y = {{(64-ACC_W){acc_y_reg[ACC_W-1]}}, acc_y_reg};
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            travel_scale_reg <= TRAVEL_SCALE_RST;
            turn_scale_reg   <= TURN_SCALE_RST;
        end
        else if (cfg_write_en)
        begin
            if (cfg_index == REG_TRAVEL_SCALE)
                travel_scale_reg <= cfg_data;
            else if (cfg_index == REG_TURN_SCALE)
                turn_scale_reg <= cfg_data;
        end
    end

    // odometry state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_left_reg   <= '0;
            last_right_reg  <= '0;
            primed_reg      <= 1'b0;
            heading_acc_reg <= '0;
            acc_x_reg       <= '0;
            acc_y_reg       <= '0;
            cnt_reg         <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                last_left_reg  <= left_position;
                last_right_reg <= right_position;
                primed_reg     <= 1'b1;
            end
            if (cmd.mid_init)
            begin
                heading_acc_reg <= heading_acc_reg + prod_reg[31:0];
                cnt_reg         <= '0;
            end
            else if (cmd.rotate)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (cmd.acc_x)
                acc_x_reg <= acc_x_reg + step[ACC_W-1:0];
            if (cmd.acc_y)
                acc_y_reg <= acc_y_reg + step[ACC_W-1:0];
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_full[63:0];
        if (cmd.load)
        begin
            sum_reg  <= dl_ext + dr_ext;
            diff_reg <= dr_ext - dl_ext;
        end
        if (cmd.ds_capture)
            ds_reg <= prod_reg[49:0];
        if (cmd.hold_capture)
            hold_reg <= prod_reg;
        if (cmd.mid_init)
        begin
            quad_reg <= quad;
            cx_reg   <= CORDIC_GAIN_Q28;
            cy_reg   <= '0;
            cz_reg   <= $signed(mid - {quad, 30'd0});
        end
        else if (cmd.rotate)
        begin
            if (!cz_reg[31])
            begin
                cx_reg <= cx_reg - ys;
                cy_reg <= cy_reg + xs;
                cz_reg <= cz_reg - $signed(atan_val);
            end
            else
            begin
                cx_reg <= cx_reg + ys;
                cy_reg <= cy_reg - xs;
                cz_reg <= cz_reg + $signed(atan_val);
            end
        end
        if (cmd.out_write)
        begin
            pose_x_reg  <= sext_x[POSE_LSB +: 32];
            pose_y_reg  <= sext_y[POSE_LSB +: 32];
            heading_reg <= heading_acc_reg[31:16];
        end
    end

    assign status.primed      = primed_reg;
    assign status.rotate_last = (cnt_reg == CNT_W'(CORDIC_N - 1));

    assign pose_x  = pose_x_reg;
    assign pose_y  = pose_y_reg;
    assign heading = heading_reg;

    // heading only moves at the midpoint step
    a_heading_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.mid_init |=> $stable(heading_acc_reg))
        else $error("heading accumulator changed outside midpoint step");

    // any load leaves the block primed
    a_primed_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> primed_reg)
        else $error("not primed after a load");

endmodule

>>> sv/ddo_ctrl.sv
// ----------------------------------------------------------------------------
// ddo_ctrl: odometry sequencer
// One-hot state machine stepping the datapath through multiply, CORDIC
// and accumulate phases, and owning the output valid flag.
// ----------------------------------------------------------------------------
module ddo_ctrl
    import ddo_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    output logic        out_valid,
    input  logic        out_stall,
    input  ddo_status_t status,
    output ddo_cmd_t    cmd
);

    typedef enum logic [11:0] {
        ST_IDLE   = 12'b0000_0000_0001,
        ST_MUL_DS = 12'b0000_0000_0010,
        ST_MUL_P  = 12'b0000_0000_0100,
        ST_MID    = 12'b0000_0000_1000,
        ST_ROTATE = 12'b0000_0001_0000,
        ST_XH     = 12'b0000_0010_0000,
        ST_XL     = 12'b0000_0100_0000,
        ST_XA     = 12'b0000_1000_0000,
        ST_YH     = 12'b0001_0000_0000,
        ST_YL     = 12'b0010_0000_0000,
        ST_YA     = 12'b0100_0000_0000,
        ST_WRITE  = 12'b1000_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   accept;
    logic   out_free;

    assign accept   = in_valid && (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.mul_op = MUL_DS;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = status.primed ? ST_MUL_DS : ST_WRITE;
                end
            end
            ST_MUL_DS:
            begin
                cmd.mul_op = MUL_DS;
                state_next = ST_MUL_P;
            end
            ST_MUL_P:
            begin
                cmd.mul_op     = MUL_P;
                cmd.ds_capture = 1'b1;
                state_next     = ST_MID;
            end
            ST_MID:
            begin
                cmd.mid_init = 1'b1;
                state_next   = ST_ROTATE;
            end
            ST_ROTATE:
            begin
                cmd.rotate = 1'b1;
                if (status.rotate_last)
                    state_next = ST_XH;
            end
            ST_XH:
            begin
                cmd.mul_op = MUL_HI;
                state_next = ST_XL;
            end
            ST_XL:
            begin
                cmd.mul_op       = MUL_LO;
                cmd.hold_capture = 1'b1;
                state_next       = ST_XA;
            end
            ST_XA:
            begin
                cmd.acc_x  = 1'b1;
                state_next = ST_YH;
            end
            ST_YH:
            begin
                cmd.mul_op = MUL_HI;
                cmd.axis_y = 1'b1;
                state_next = ST_YL;
            end
            ST_YL:
            begin
                cmd.mul_op       = MUL_LO;
                cmd.axis_y       = 1'b1;
                cmd.hold_capture = 1'b1;
                state_next       = ST_YA;
            end
            ST_YA:
            begin
                cmd.acc_y  = 1'b1;
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                if (out_free)
                begin
                    cmd.out_write = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output valid flag
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_write)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    // a primed request goes straight into the multiply phase
    a_primed_start: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && status.primed) |=> (state_reg == ST_MUL_DS))
        else $error("primed request did not start the multiply phase");

    // the rotation runs until the last step is flagged
    a_rotate_runs: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROTATE && !status.rotate_last) |=> (state_reg == ST_ROTATE))
        else $error("rotation left early");

    // a completed write raises valid and frees the input
    a_write_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WRITE && out_free) |=> (out_valid_reg && state_reg == ST_IDLE))
        else $error("result write did not complete");

endmodule

>>> sv/diff_drive_odometry.sv
// ----------------------------------------------------------------------------
// diff_drive_odometry: differential-drive wheel odometry
// A priming request goes straight to the output write; any later request
// passes through the shared multiplier phases, the one-step-per-cycle
// CORDIC rotation and the accumulate phases. A new request is taken only
// once the previous pose is written, as in_stall is high outside idle.
// Reset (rst_n, async low): pose/heading accumulators and priming cleared,
// scales to their defaults, output registers not reset; no clearing pass.
// ----------------------------------------------------------------------------
module diff_drive_odometry
    import ddo_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [15:0]           left_position,
    input  logic [15:0]           right_position,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic signed [31:0]    pose_x,
    output logic signed [31:0]    pose_y,
    output logic [15:0]           heading,
    input  logic                  cfg_write_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data
);

    ddo_cmd_t    cmd;
    ddo_status_t status;

    // sequencer
    ddo_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // arithmetic
    ddo_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .left_position  (left_position),
        .right_position (right_position),
        .cfg_write_en   (cfg_write_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .pose_x         (pose_x),
        .pose_y         (pose_y),
        .heading        (heading)
    );

endmodule
